// ===== sv/scit_pkg.sv =====
// ----------------------------------------------------------------------------
// scit_pkg: shared types for the segment/circle hit test pipeline
// Projection-mode codes and the control word that travels with each item.
// ----------------------------------------------------------------------------
package scit_pkg;

  // How the projection parameter t is settled for one item
  typedef enum logic [1:0] {
    TM_ZERO = 2'd0,  // centre behind or level with the start, or zero-length segment
    TM_ONE  = 2'd1,  // centre at or beyond the end
    TM_DIV  = 2'd2   // t from the restoring divider
  } tmode_e;

  // Per-stage control word
  typedef struct packed {
    logic   valid;
    tmode_e mode;
  } scit_ctl_t;

endpackage

// ===== sv/segment_circle_intersection_test.sv =====
// ----------------------------------------------------------------------------
// segment_circle_intersection_test: segment versus circle hit test
// Fixed-point test of whether segment A-B comes within radius of centre C.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the segment endpoints, the circle centre and the radius and pulse
//   start_i; the word is taken at any edge where start_i is high and busy_o
//   is low. busy_o stays low, so a new word may enter every cycle.
//   Each word yields one result: hit_o is valid for the single cycle in
//   which done_o is high, in the order the words were taken.
//   The pipeline has four front stages (differences, products, sums, clamp
//   of t), one divider stage per fraction bit of t, and four back stages
//   (scale, offset, square, compare). Throughput is one word per cycle.
//   Reset clears all valid bits; words in flight are dropped and done_o
//   stays low until new words come through. The receiver cannot stall, so
//   the pipeline never holds.
// ----------------------------------------------------------------------------
module segment_circle_intersection_test import scit_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [COORD_WIDTH-1:0] start_x_i,
  input  logic [COORD_WIDTH-1:0] start_y_i,
  input  logic [COORD_WIDTH-1:0] end_x_i,
  input  logic [COORD_WIDTH-1:0] end_y_i,
  input  logic [COORD_WIDTH-1:0] centre_x_i,
  input  logic [COORD_WIDTH-1:0] centre_y_i,
  input  logic [COORD_WIDTH-2:0] radius_i,
  output logic                   done_o,
  output logic                   hit_o
);

  localparam int LW     = 2 * COORD_WIDTH + 2;
  localparam int SIDE_W = 6 * COORD_WIDTH + 2;
  localparam int QW     = (FRAC_BITS > 0) ? FRAC_BITS : 1;

  scit_ctl_t         f_ctl, d_ctl;
  logic [LW-1:0]     f_rem, f_len;
  logic [SIDE_W-1:0] f_side, d_side;
  logic [QW-1:0]     d_quo;

  // Pipeline never stalls
  assign busy_o = 1'b0;

  scit_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .centre_x_i (centre_x_i),
    .centre_y_i (centre_y_i),
    .radius_i   (radius_i),
    .ctl_o      (f_ctl),
    .rem_o      (f_rem),
    .len_o      (f_len),
    .side_o     (f_side)
  );

  scit_div #(
    .LW        (LW),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SIDE_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (f_ctl),
    .rem_i  (f_rem),
    .len_i  (f_len),
    .side_i (f_side),
    .ctl_o  (d_ctl),
    .quo_o  (d_quo),
    .side_o (d_side)
  );

  scit_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (d_ctl),
    .quo_i  (d_quo),
    .side_i (d_side),
    .done_o (done_o),
    .hit_o  (hit_o)
  );

endmodule

// ===== sv/scit_front.sv =====
// ----------------------------------------------------------------------------
// scit_front: difference, product and classification stages
// Four stages: coordinate differences, products, sums, clamp decision for t.
// ----------------------------------------------------------------------------
module scit_front import scit_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [COORD_WIDTH-1:0]       start_x_i,
  input  logic [COORD_WIDTH-1:0]       start_y_i,
  input  logic [COORD_WIDTH-1:0]       end_x_i,
  input  logic [COORD_WIDTH-1:0]       end_y_i,
  input  logic [COORD_WIDTH-1:0]       centre_x_i,
  input  logic [COORD_WIDTH-1:0]       centre_y_i,
  input  logic [COORD_WIDTH-2:0]       radius_i,
  output scit_ctl_t                    ctl_o,
  output logic [2*COORD_WIDTH+1:0]     rem_o,
  output logic [2*COORD_WIDTH+1:0]     len_o,
  output logic [6*COORD_WIDTH+1:0]     side_o
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;        // signed difference
  localparam int PW   = 2 * DW;       // signed product
  localparam int LW   = 2 * W + 2;    // squared length / remainder
  localparam int DOTW = 2 * W + 3;    // signed dot product
  localparam int RW   = W - 1;
  localparam int RSW  = 2 * RW;

  // Stage 1: differences d = B - A, e = C - A
  logic                 v1_q;
  logic [DW-1:0]        dx1_q, dy1_q, ex1_q, ey1_q;
  logic [RW-1:0]        r1_q;
  logic [DW-1:0]        dx1_d, dy1_d, ex1_d, ey1_d;

  always_comb begin
    dx1_d = {end_x_i[W-1], end_x_i} - {start_x_i[W-1], start_x_i};
    dy1_d = {end_y_i[W-1], end_y_i} - {start_y_i[W-1], start_y_i};
    ex1_d = {centre_x_i[W-1], centre_x_i} - {start_x_i[W-1], start_x_i};
    ey1_d = {centre_y_i[W-1], centre_y_i} - {start_y_i[W-1], start_y_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q <= dx1_d;
    dy1_q <= dy1_d;
    ex1_q <= ex1_d;
    ey1_q <= ey1_d;
    r1_q  <= radius_i;
  end

  // Stage 2: products
  logic                 v2_q;
  logic signed [PW-1:0] pxx2_q, pyy2_q, pex2_q, pey2_q;
  logic [RSW-1:0]       rsq2_q;
  logic [DW-1:0]        dx2_q, dy2_q, ex2_q, ey2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pxx2_q <= $signed(dx1_q) * $signed(dx1_q);
    pyy2_q <= $signed(dy1_q) * $signed(dy1_q);
    pex2_q <= $signed(ex1_q) * $signed(dx1_q);
    pey2_q <= $signed(ey1_q) * $signed(dy1_q);
    rsq2_q <= r1_q * r1_q;
    dx2_q  <= dx1_q;
    dy2_q  <= dy1_q;
    ex2_q  <= ex1_q;
    ey2_q  <= ey1_q;
  end

  // Stage 3: squared length and dot product
  logic                 v3_q;
  logic [LW-1:0]        len3_q;
  logic [DOTW-1:0]      dot3_q;
  logic [RSW-1:0]       rsq3_q;
  logic [DW-1:0]        dx3_q, dy3_q, ex3_q, ey3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    len3_q <= pxx2_q + pyy2_q;
    dot3_q <= {pex2_q[PW-1], pex2_q} + {pey2_q[PW-1], pey2_q};
    rsq3_q <= rsq2_q;
    dx3_q  <= dx2_q;
    dy3_q  <= dy2_q;
    ex3_q  <= ex2_q;
    ey3_q  <= ey2_q;
  end

  // Stage 4: clamp decision for t
  logic                 v4_q;
  tmode_e               mode4_q, mode4_d;
  logic [LW-1:0]        rem4_q, len4_q;
  logic [6*W+1:0]       side4_q;

  always_comb begin
    if (dot3_q[DOTW-1] || (dot3_q == '0)) begin
      mode4_d = TM_ZERO;
    end else if (dot3_q[LW-1:0] >= len3_q) begin
      mode4_d = TM_ONE;
    end else begin
      mode4_d = TM_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode4_q <= mode4_d;
    rem4_q  <= dot3_q[LW-1:0];
    len4_q  <= len3_q;
    side4_q <= {dx3_q, dy3_q, ex3_q, ey3_q, rsq3_q};
  end

  assign ctl_o  = '{valid: v4_q, mode: mode4_q};
  assign rem_o  = rem4_q;
  assign len_o  = len4_q;
  assign side_o = side4_q;

endmodule

// ===== sv/scit_div.sv =====
// ----------------------------------------------------------------------------
// scit_div: pipelined restoring divider for the projection parameter
// One quotient bit per stage, FRAC_BITS stages; side data rides along.
// ----------------------------------------------------------------------------
module scit_div import scit_pkg::*; #(
  parameter int LW        = 66,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 194
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  scit_ctl_t                             ctl_i,
  input  logic [LW-1:0]                         rem_i,
  input  logic [LW-1:0]                         len_i,
  input  logic [SIDE_W-1:0]                     side_i,
  output scit_ctl_t                             ctl_o,
  output logic [((FRAC_BITS > 0) ? FRAC_BITS : 1)-1:0] quo_o,
  output logic [SIDE_W-1:0]                     side_o
);

  localparam int QW = (FRAC_BITS > 0) ? FRAC_BITS : 1;

  scit_ctl_t         ctl_s  [FRAC_BITS+1];
  logic [LW-1:0]     rem_s  [FRAC_BITS+1];
  logic [LW-1:0]     len_s  [FRAC_BITS+1];
  logic [QW-1:0]     quo_s  [FRAC_BITS+1];
  logic [SIDE_W-1:0] side_s [FRAC_BITS+1];

  assign ctl_s[0]  = ctl_i;
  assign rem_s[0]  = rem_i;
  assign len_s[0]  = len_i;
  assign quo_s[0]  = '0;
  assign side_s[0] = side_i;

  // Each stage: shift remainder, trial subtract, shift in one quotient bit
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_stage
    logic              vld_q;
    tmode_e            mode_q;
    logic [LW-1:0]     rem_q, len_q, rem_d, rem2;
    logic [QW-1:0]     quo_q, quo_d;
    logic [SIDE_W-1:0] side_q;
    logic              ge;

    always_comb begin
      rem2  = {rem_s[k-1][LW-2:0], 1'b0};
      ge    = (rem2 >= len_s[k-1]);
      rem_d = ge ? (rem2 - len_s[k-1]) : rem2;
      quo_d = (quo_s[k-1] << 1) | QW'(ge);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= ctl_s[k-1].valid;
      end
    end

    always_ff @(posedge clk_i) begin
      mode_q <= ctl_s[k-1].mode;
      rem_q  <= rem_d;
      len_q  <= len_s[k-1];
      quo_q  <= quo_d;
      side_q <= side_s[k-1];
    end

    assign ctl_s[k]  = '{valid: vld_q, mode: mode_q};
    assign rem_s[k]  = rem_q;
    assign len_s[k]  = len_q;
    assign quo_s[k]  = quo_q;
    assign side_s[k] = side_q;
  end

  assign ctl_o  = ctl_s[FRAC_BITS];
  assign quo_o  = quo_s[FRAC_BITS];
  assign side_o = side_s[FRAC_BITS];

endmodule

// ===== sv/scit_back.sv =====
// ----------------------------------------------------------------------------
// scit_back: closest point and distance compare
// Four stages: scale d by t, offset to centre, square, sum and compare.
// ----------------------------------------------------------------------------
module scit_back import scit_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  scit_ctl_t                             ctl_i,
  input  logic [((FRAC_BITS > 0) ? FRAC_BITS : 1)-1:0] quo_i,
  input  logic [6*COORD_WIDTH+1:0]              side_i,
  output logic                                  done_o,
  output logic                                  hit_o
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;
  localparam int RSW = 2 * (W - 1);
  localparam int OW  = DW + FRAC_BITS + 2;  // d * t
  localparam int QW2 = W + 2;               // P - C
  localparam int SW  = 2 * QW2;             // squares and their sum

  // Unpack side data
  logic [DW-1:0]  dx, dy, ex, ey;
  logic [RSW-1:0] rsq;

  assign rsq = side_i[RSW-1:0];
  assign ey  = side_i[RSW+DW-1 -: DW];
  assign ex  = side_i[RSW+2*DW-1 -: DW];
  assign dy  = side_i[RSW+3*DW-1 -: DW];
  assign dx  = side_i[RSW+4*DW-1 -: DW];

  // Stage 5: t from the clamp mode, offsets d * t
  logic [FRAC_BITS:0]   t;
  logic                 v5_q;
  logic signed [OW-1:0] offx5_q, offy5_q;
  logic [DW-1:0]        ex5_q, ey5_q;
  logic [RSW-1:0]       rsq5_q;

  always_comb begin
    case (ctl_i.mode)
      TM_ONE:  t = (FRAC_BITS+1)'(1) << FRAC_BITS;
      TM_DIV:  t = (FRAC_BITS+1)'(quo_i);
      default: t = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    offx5_q <= $signed(dx) * $signed({1'b0, t});
    offy5_q <= $signed(dy) * $signed({1'b0, t});
    ex5_q   <= ex;
    ey5_q   <= ey;
    rsq5_q  <= rsq;
  end

  // Stage 6: P - C = floor(d * t / 2^F) - e
  logic signed [OW-1:0]  shx, shy;
  logic                  v6_q;
  logic signed [QW2-1:0] qx6_q, qy6_q;
  logic [RSW-1:0]        rsq6_q;

  assign shx = offx5_q >>> FRAC_BITS;
  assign shy = offy5_q >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    qx6_q  <= {shx[DW-1], shx[DW-1:0]} - {ex5_q[DW-1], ex5_q};
    qy6_q  <= {shy[DW-1], shy[DW-1:0]} - {ey5_q[DW-1], ey5_q};
    rsq6_q <= rsq5_q;
  end

  // Stage 7: squares
  logic                 v7_q;
  logic signed [SW-1:0] sqx7_q, sqy7_q;
  logic [RSW-1:0]       rsq7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx7_q <= qx6_q * qx6_q;
    sqy7_q <= qy6_q * qy6_q;
    rsq7_q <= rsq6_q;
  end

  // Stage 8: squared distance against squared radius, touching counts
  logic [SW-1:0] dist_sq;
  logic          v8_q;
  logic          hit8_q;

  assign dist_sq = sqx7_q + sqy7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit8_q <= (dist_sq <= SW'(rsq7_q));
  end

  assign done_o = v8_q;
  assign hit_o  = hit8_q;

endmodule

// ===== test/tb_segment_circle_intersection_test.sv =====
// ----------------------------------------------------------------------------
// tb_segment_circle_intersection_test: self-checking bench for the hit test
// Drives segment/circle query words through the pipeline with random gaps,
// predicts each hit flag in wide exact integer arithmetic and compares every
// done_o strobe with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_segment_circle_intersection_test;
  timeunit 1ns;
  timeprecision 1ps;

  import scit_pkg::*;

  localparam int CW   = 32;
  localparam int FRAC = 16;
  localparam logic [CW-1:0] ONE  = 32'h0001_0000;
  localparam logic [CW-1:0] SMIN = 32'h8000_0000;
  localparam logic [CW-1:0] SMAX = 32'h7fff_ffff;
  localparam logic [CW-2:0] RMAX = 31'h7fff_ffff;
  localparam int RAND_WORDS = 1350;

  // One query word as it enters the block
  typedef struct {
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-2:0] r;
  } seg_query_t;

  // Expected hit flags, oldest first, plus the exact hit predictor
  class HitScoreboard;
    bit expected_hits[$];
    int mismatches;

    function automatic logic signed [127:0] sx(logic [CW-1:0] v);
      return $signed({{(128-CW){v[CW-1]}}, v});
    endfunction

    // Squared distance from the centre to the closest grid point of the segment
    function automatic logic signed [127:0] closest_dist_sq(seg_query_t q);
      logic signed [127:0] dx, dy, ex, ey, len_sq, dot, t, qx, qy;
      dx = sx(q.bx) - sx(q.ax);
      dy = sx(q.by) - sx(q.ay);
      ex = sx(q.cx) - sx(q.ax);
      ey = sx(q.cy) - sx(q.ay);
      len_sq = dx * dx + dy * dy;
      if (len_sq == 0) return ex * ex + ey * ey;
      dot = ex * dx + ey * dy;
      // t clamped to [0,1], truncated to FRAC fraction bits
      if (dot <= 0) t = 0;
      else if (dot >= len_sq) t = 128'sd1 <<< FRAC;
      else t = (dot <<< FRAC) / len_sq;
      // floor of d*t on the coordinate grid, then offset from the centre
      qx = ((dx * t) >>> FRAC) - ex;
      qy = ((dy * t) >>> FRAC) - ey;
      return qx * qx + qy * qy;
    endfunction

    function automatic bit predict_hit(seg_query_t q);
      logic signed [127:0] rr;
      rr = $signed({{(129-CW){1'b0}}, q.r});
      return closest_dist_sq(q) <= rr * rr;
    endfunction

    function void note_query(seg_query_t q);
      expected_hits.push_back(predict_hit(q));
    endfunction

    function void check_hit(logic actual);
      bit exp_hit;
      if (expected_hits.size() == 0) begin
        mismatches++;
        $error("hit: expected none (no word outstanding), actual %0b", actual);
        return;
      end
      exp_hit = expected_hits.pop_front();
      if (actual !== exp_hit) begin
        mismatches++;
        $error("hit: expected %0b, actual %0b", exp_hit, actual);
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  logic          busy_o;
  logic [CW-1:0] start_x_i;
  logic [CW-1:0] start_y_i;
  logic [CW-1:0] end_x_i;
  logic [CW-1:0] end_y_i;
  logic [CW-1:0] centre_x_i;
  logic [CW-1:0] centre_y_i;
  logic [CW-2:0] radius_i;
  logic          done_o;
  logic          hit_o;

  HitScoreboard sb;
  bit           no_idle;

  segment_circle_intersection_test #(
    .COORD_WIDTH(CW),
    .FRAC_BITS  (FRAC)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .centre_x_i(centre_x_i),
    .centre_y_i(centre_y_i),
    .radius_i  (radius_i),
    .done_o    (done_o),
    .hit_o     (hit_o)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Results cannot be held off: check every strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_hit(hit_o);
  end

  function automatic seg_query_t mk(logic [CW-1:0] ax, logic [CW-1:0] ay,
                                    logic [CW-1:0] bx, logic [CW-1:0] by,
                                    logic [CW-1:0] cx, logic [CW-1:0] cy,
                                    logic [CW-2:0] r);
    seg_query_t q;
    q.ax = ax; q.ay = ay; q.bx = bx; q.by = by;
    q.cx = cx; q.cy = cy; q.r = r;
    return q;
  endfunction

  // Present one word after a random gap; returns at the edge that takes it
  task automatic send_query(input seg_query_t q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    start_x_i  <= q.ax;
    start_y_i  <= q.ay;
    end_x_i    <= q.bx;
    end_y_i    <= q.by;
    centre_x_i <= q.cx;
    centre_y_i <= q.cy;
    radius_i   <= q.r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_query(q);
  endtask

  function automatic logic [CW-1:0] near(logic [CW-1:0] base, int span);
    return base + CW'($urandom_range(0, 2 * span)) - CW'(span);
  endfunction

  // Random word: full-range noise, local geometry, near-touching radii, degenerate
  function automatic seg_query_t rand_query();
    seg_query_t q;
    int kind, span;
    logic [CW-1:0] bx, by;
    longint rad;
    kind = $urandom_range(0, 9);
    case ($urandom_range(0, 2))
      0: span = 1 << 4;
      1: span = 1 << 12;
      default: span = 1 << 20;
    endcase
    bx = $urandom;
    by = $urandom;
    q = mk(near(bx, span), near(by, span), near(bx, span), near(by, span),
           near(bx, span), near(by, span), 31'($urandom_range(0, 2 * span)));
    if (kind <= 1) begin
      q = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 31'($urandom));
    end else if (kind == 9) begin
      case ($urandom_range(0, 3))
        0: begin q.bx = q.ax; q.by = q.ay; end
        1: begin q.cx = q.ax; q.cy = q.ay; end
        2: q.by = q.ay;
        default: q.bx = q.ax;
      endcase
    end
    // Radius on the edge of the true distance
    if (kind >= 6) begin
      rad = longint'($floor($sqrt(real'(sb.closest_dist_sq(q)))));
      rad = rad + $urandom_range(0, 2) - 1;
      if (rad < 0) rad = 0;
      if (rad > longint'(RMAX)) rad = longint'(RMAX);
      q.r = 31'(rad);
    end
    return q;
  endfunction

  // Stimulus
  initial begin
    seg_query_t directed[$];
    sb         = new();
    no_idle    = 1'b0;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    start_x_i  = '0;
    start_y_i  = '0;
    end_x_i    = '0;
    end_y_i    = '0;
    centre_x_i = '0;
    centre_y_i = '0;
    radius_i   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all zero, zero radius: touching at a point
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    // zero-length segment, 3-4-5 distance: touching, then just outside
    directed.push_back(mk(ONE, ONE, ONE, ONE, 4 * ONE, 5 * ONE, 31'(5 * ONE)));
    directed.push_back(mk(ONE, ONE, ONE, ONE, 4 * ONE, 5 * ONE, 31'(5 * ONE - 1)));
    // centre behind the start
    directed.push_back(mk(0, 0, 10 * ONE, 0, -3 * ONE, 0, 31'(3 * ONE)));
    directed.push_back(mk(0, 0, 10 * ONE, 0, -3 * ONE, 0, 31'(2 * ONE)));
    // centre beyond the end
    directed.push_back(mk(0, 0, 10 * ONE, 0, 13 * ONE, 4 * ONE, 31'(5 * ONE)));
    directed.push_back(mk(0, 0, 10 * ONE, 0, 13 * ONE, 4 * ONE, 31'(5 * ONE - 1)));
    // interior projection, touching and just missing
    directed.push_back(mk(0, 0, 10 * ONE, 0, 5 * ONE, 3 * ONE, 31'(3 * ONE)));
    directed.push_back(mk(0, 0, 10 * ONE, 0, 5 * ONE, 3 * ONE, 31'(3 * ONE - 1)));
    // coordinate and radius extremes
    directed.push_back(mk(SMIN, SMIN, SMAX, SMAX, 0, 0, 0));
    directed.push_back(mk(SMAX, SMIN, SMIN, SMAX, SMAX, SMAX, RMAX));
    directed.push_back(mk(SMIN, SMIN, SMIN, SMIN, SMAX, SMAX, RMAX));
    directed.push_back(mk(SMAX, SMAX, SMAX, SMIN, SMIN, SMAX, 0));
    directed.push_back(mk(SMIN, SMAX, SMAX, SMIN, SMAX, SMIN, 31'h4000_0000));
    directed.push_back(mk(0, 0, 0, 0, 0, 0, RMAX));
    // sub-unit coordinates: t from the divider with fraction bits only
    directed.push_back(mk(1, 0, 3, 0, 2, 5, 5));
    directed.push_back(mk(1, 0, 3, 0, 2, 5, 4));
    // negative direction, negative offsets rounded toward minus infinity
    directed.push_back(mk(10 * ONE, 10 * ONE, -10 * ONE, -7 * ONE, 3 * ONE, -2 * ONE,
                          31'(ONE)));
    directed.push_back(mk(7, 3, -5, -11, 1, 0, 3));
    directed.push_back(mk(0, 0, -3, -7, -2, -1, 1));
    foreach (directed[i]) send_query(directed[i]);

    // Random part, with occasional back-to-back stretches
    for (int n = 0; n < RAND_WORDS; n++) begin
      if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
      send_query(rand_query());
    end
    start_i <= 1'b0;

    // Drain the pipeline, then allow for stray strobes
    while (sb.expected_hits.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
